// File: sv/see_pkg.sv
// Shared types, codes and the microcode program of the string escape encoder.
package see_pkg;

  localparam int CP_W    = 21;
  localparam int PC_W    = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_DOUBLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EOL_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EOL_FIRST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EOL_SECOND   = 3'd4;

  // Input commands.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Characters the encoder looks at or produces.
  localparam logic [CP_W-1:0] CH_BS     = 21'h08;
  localparam logic [CP_W-1:0] CH_TAB    = 21'h09;
  localparam logic [CP_W-1:0] CH_LF     = 21'h0A;
  localparam logic [CP_W-1:0] CH_FF     = 21'h0C;
  localparam logic [CP_W-1:0] CH_CR     = 21'h0D;
  localparam logic [CP_W-1:0] CH_SPACE  = 21'h20;
  localparam logic [CP_W-1:0] CH_DQUOTE = 21'h22;
  localparam logic [CP_W-1:0] CH_SQUOTE = 21'h27;
  localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CP_W-1:0] CH_DEL    = 21'h7F;
  localparam logic [CP_W-1:0] CH_HIGH   = 21'h80;
  localparam logic [CP_W-1:0] CH_ASTRAL = 21'h10000;

  // Emission condition of a control word.
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_GE1    = 2'd1;
  localparam logic [1:0] COND_GE2    = 2'd2;

  // Character source of a control word.
  localparam logic [1:0] SRC_LIT  = 2'd0;
  localparam logic [1:0] SRC_CP   = 2'd1;
  localparam logic [1:0] SRC_EOL1 = 2'd2;
  localparam logic [1:0] SRC_EOL2 = 2'd3;
  localparam logic       HEX_OFF  = 1'b0;
  localparam logic       HEX_ON   = 1'b1;

  // When the emitted character closes the item.
  localparam logic [1:0] LAST_NEVER  = 2'd0;
  localparam logic [1:0] LAST_ALWAYS = 2'd1;
  localparam logic [1:0] LAST_LEN0   = 2'd2;
  localparam logic [1:0] LAST_LEN1   = 2'd3;

  // Sequencing operation.
  localparam logic [1:0] OP_NEXT = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_TAIL = 2'd2;

  // Routine entry points in the program.
  localparam logic [PC_W-1:0] A_LF_CR = 6'd0;
  localparam logic [PC_W-1:0] A_LF    = 6'd2;
  localparam logic [PC_W-1:0] A_CRPFX = 6'd6;
  localparam logic [PC_W-1:0] A_TAB   = 6'd10;
  localparam logic [PC_W-1:0] A_BS    = 6'd12;
  localparam logic [PC_W-1:0] A_FF    = 6'd14;
  localparam logic [PC_W-1:0] A_XHEX  = 6'd16;
  localparam logic [PC_W-1:0] A_ESC   = 6'd20;
  localparam logic [PC_W-1:0] A_PLAIN = 6'd21;
  localparam logic [PC_W-1:0] A_U4    = 6'd22;
  localparam logic [PC_W-1:0] A_U8    = 6'd28;

  typedef struct packed {
    logic [1:0] cond;
    logic [1:0] src;
    logic       hex;
    logic [6:0] lit;
    logic [2:0] nib;
    logic [1:0] lastc;
    logic       prefix;
    logic [1:0] op;
  } ucw_t;

  typedef struct packed {
    logic            has;
    logic [PC_W-1:0] entry;
  } route_t;

  function automatic ucw_t mk(input logic [1:0] cond, input logic [1:0] src,
                              input logic hex, input logic [6:0] lit,
                              input logic [2:0] nib, input logic [1:0] lastc,
                              input logic prefix, input logic [1:0] op);
    ucw_t w;
    w.cond = cond; w.src = src; w.hex = hex; w.lit = lit; w.nib = nib;
    w.lastc = lastc; w.prefix = prefix; w.op = op;
    return w;
  endfunction

  function automatic ucw_t lit_w(input logic [6:0] lit, input logic [1:0] lastc,
                                 input logic prefix, input logic [1:0] op);
    return mk(COND_ALWAYS, SRC_LIT, HEX_OFF, lit, 3'd0, lastc, prefix, op);
  endfunction

  function automatic ucw_t hex_w(input logic [2:0] nib, input logic [1:0] op);
    ucw_t w;
    w = mk(COND_ALWAYS, SRC_LIT, HEX_ON, 7'h00, nib, LAST_NEVER, 1'b0, op);
    if (op == OP_END) begin
      w.lastc = LAST_ALWAYS;
    end
    return w;
  endfunction

  // The control program, one word per step.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = lit_w(7'h00, LAST_NEVER, 1'b0, OP_END);
    unique case (pc)
      // LF, entered at the first word when a CR is pending.
      6'd0:  w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd1:  w = lit_w(7'h72, LAST_NEVER, 1'b0, OP_NEXT);
      6'd2:  w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd3:  w = lit_w(7'h6E, LAST_LEN0, 1'b0, OP_NEXT);
      6'd4:  w = mk(COND_GE1, SRC_EOL1, HEX_OFF, 7'h00, 3'd0, LAST_LEN1, 1'b0, OP_NEXT);
      6'd5:  w = mk(COND_GE2, SRC_EOL2, HEX_OFF, 7'h00, 3'd0, LAST_ALWAYS, 1'b0, OP_END);
      // Pending CR flushed ahead of another character or on finish.
      6'd6:  w = lit_w(7'h5C, LAST_NEVER, 1'b1, OP_NEXT);
      6'd7:  w = lit_w(7'h72, LAST_LEN0, 1'b1, OP_NEXT);
      6'd8:  w = mk(COND_GE1, SRC_EOL1, HEX_OFF, 7'h00, 3'd0, LAST_LEN1, 1'b1, OP_NEXT);
      6'd9:  w = mk(COND_GE2, SRC_EOL2, HEX_OFF, 7'h00, 3'd0, LAST_ALWAYS, 1'b1, OP_TAIL);
      6'd10: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd11: w = lit_w(7'h74, LAST_ALWAYS, 1'b0, OP_END);
      6'd12: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd13: w = lit_w(7'h62, LAST_ALWAYS, 1'b0, OP_END);
      6'd14: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd15: w = lit_w(7'h66, LAST_ALWAYS, 1'b0, OP_END);
      6'd16: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd17: w = lit_w(7'h78, LAST_NEVER, 1'b0, OP_NEXT);
      6'd18: w = hex_w(3'd1, OP_NEXT);
      6'd19: w = hex_w(3'd0, OP_END);
      // Escaped pass-through; plain pass-through enters at the second word.
      6'd20: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd21: w = mk(COND_ALWAYS, SRC_CP, HEX_OFF, 7'h00, 3'd0, LAST_ALWAYS, 1'b0, OP_END);
      6'd22: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd23: w = lit_w(7'h75, LAST_NEVER, 1'b0, OP_NEXT);
      6'd24: w = hex_w(3'd3, OP_NEXT);
      6'd25: w = hex_w(3'd2, OP_NEXT);
      6'd26: w = hex_w(3'd1, OP_NEXT);
      6'd27: w = hex_w(3'd0, OP_END);
      6'd28: w = lit_w(7'h5C, LAST_NEVER, 1'b0, OP_NEXT);
      6'd29: w = lit_w(7'h55, LAST_NEVER, 1'b0, OP_NEXT);
      6'd30: w = hex_w(3'd7, OP_NEXT);
      6'd31: w = hex_w(3'd6, OP_NEXT);
      6'd32: w = hex_w(3'd5, OP_NEXT);
      6'd33: w = hex_w(3'd4, OP_NEXT);
      6'd34: w = hex_w(3'd3, OP_NEXT);
      6'd35: w = hex_w(3'd2, OP_NEXT);
      6'd36: w = hex_w(3'd1, OP_NEXT);
      6'd37: w = hex_w(3'd0, OP_END);
      default: w = lit_w(7'h00, LAST_NEVER, 1'b0, OP_END);
    endcase
    return w;
  endfunction

  // Picks the routine for a character other than LF; has is low for a CR.
  function automatic route_t classify(input logic [CP_W-1:0] cp, input logic quote_double,
                                      input logic escape_high);
    route_t r;
    r.has   = 1'b1;
    r.entry = A_PLAIN;
    if (cp < CH_SPACE || cp == CH_DEL) begin
      if (cp == CH_TAB) begin
        r.entry = A_TAB;
      end else if (cp == CH_CR) begin
        r.has = 1'b0;
      end else if (cp == CH_BS) begin
        r.entry = A_BS;
      end else if (cp == CH_FF) begin
        r.entry = A_FF;
      end else begin
        r.entry = A_XHEX;
      end
    end else if (cp < CH_HIGH || !escape_high) begin
      if ((quote_double && cp == CH_DQUOTE) || (!quote_double && cp == CH_SQUOTE) ||
          cp == CH_BSLASH) begin
        r.entry = A_ESC;
      end
    end else if (cp < CH_ASTRAL) begin
      r.entry = A_U4;
    end else begin
      r.entry = A_U8;
    end
    return r;
  endfunction

endpackage

// File: sv/see_char_mux.sv
// Datapath that forms the output character named by one control word.
module see_char_mux (
  input  see_pkg::ucw_t                cw,
  input  logic [see_pkg::CP_W-1:0]     cp,
  input  logic [see_pkg::CP_W-1:0]     eol_first,
  input  logic [see_pkg::CP_W-1:0]     eol_second,
  output logic [see_pkg::CP_W-1:0]     ch
);
  import see_pkg::*;

  logic [31:0] cp_wide;
  logic [3:0]  nibble;
  logic [6:0]  hex_ascii;

  assign cp_wide = {11'd0, cp};

  always_comb begin
    unique case (cw.nib)
      3'd0: nibble = cp_wide[3:0];
      3'd1: nibble = cp_wide[7:4];
      3'd2: nibble = cp_wide[11:8];
      3'd3: nibble = cp_wide[15:12];
      3'd4: nibble = cp_wide[19:16];
      3'd5: nibble = cp_wide[23:20];
      3'd6: nibble = cp_wide[27:24];
      3'd7: nibble = cp_wide[31:28];
      default: nibble = 4'd0;
    endcase
  end

  // Uppercase hex digit.
  assign hex_ascii = (nibble < 4'd10) ? (7'h30 + {3'd0, nibble}) : (7'h37 + {3'd0, nibble});

  always_comb begin
    if (cw.hex) begin
      ch = {14'd0, hex_ascii};
    end else begin
      unique case (cw.src)
        SRC_LIT:  ch = {14'd0, cw.lit};
        SRC_CP:   ch = cp;
        SRC_EOL1: ch = eol_first;
        SRC_EOL2: ch = eol_second;
        default:  ch = {14'd0, cw.lit};
      endcase
    end
  end

endmodule

// File: sv/string_escape_encoder.sv
// Top level of the string escape encoder: microcode sequencer and output register.
//
// The input channel (in_valid/in_ready) takes one word per item: a command and a
// code point. Encode commands produce the escaped form of the code point, one
// character per output word, with out_last set on the final character of the
// item. A CR produces nothing at once; it is held and flushed as \r plus the line
// end ahead of the next character, joined into \r\n with a following LF, or
// flushed by a finish command. A finish with nothing held produces no words.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes register
// cfg_index with cfg_data; change it only while the encoder is idle.
// Timing: one microcode step per cycle unless a stalled receiver holds an emitting
// step; each step emits at most one character. An item runs 0 to 14 steps: plain
// character 1, LF 4 (6 with a held CR), \x escape 4, \U escape 10, plus 4 for a held
// CR flushed ahead of another character; a CR or an empty finish takes none.
// The accepted item is registered, then the first step loads the output register.
// in_ready is low while a routine runs. A stalled receiver (out_ready low)
// holds the output register and freezes the sequencer on its next emitting step.
// Reset clears the held CR and loads the register reset values.
module string_escape_encoder #(
  parameter int unsigned EOL_MAX_LEN = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [see_pkg::CP_W-1:0]            in_code_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [see_pkg::CP_W-1:0]            out_char,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [see_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [see_pkg::CP_W-1:0]            cfg_data
);
  import see_pkg::*;

  localparam logic [1:0] EolCap = (EOL_MAX_LEN < 2) ? 2'(EOL_MAX_LEN) : 2'd2;

  logic            quote_double_r, escape_high_r;
  logic [1:0]      eol_length_r;
  logic [CP_W-1:0] eol_first_r, eol_second_r;

  logic            pending_r, pending_nxt;
  logic            busy_r, busy_nxt;
  logic            tail_r, tail_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PC_W-1:0] main_r, main_nxt;
  logic [CP_W-1:0] cp_r, cp_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] out_char_r, out_char_nxt;
  logic            out_last_r, out_last_nxt;

  logic            accept, slot_free, emit_ok, last_now, fire;
  logic [1:0]      len_eff;
  ucw_t            cw;
  route_t          route;
  logic [CP_W-1:0] ch;

  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign len_eff   = (eol_length_r > EolCap) ? EolCap : eol_length_r;

  assign cw    = ucode(pc_r);
  assign route = classify(in_code_point, quote_double_r, escape_high_r);

  see_char_mux u_char_mux (
    .cw         (cw),
    .cp         (cp_r),
    .eol_first  (eol_first_r),
    .eol_second (eol_second_r),
    .ch         (ch)
  );

  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS: emit_ok = 1'b1;
      COND_GE1:    emit_ok = (len_eff >= 2'd1);
      COND_GE2:    emit_ok = (len_eff >= 2'd2);
      default:     emit_ok = 1'b0;
    endcase
  end

  // A flush ahead of another character never carries the last mark.
  always_comb begin
    unique case (cw.lastc)
      LAST_NEVER:  last_now = 1'b0;
      LAST_ALWAYS: last_now = 1'b1;
      LAST_LEN0:   last_now = (len_eff == 2'd0);
      LAST_LEN1:   last_now = (len_eff == 2'd1);
      default:     last_now = 1'b0;
    endcase
    if (cw.prefix && tail_r) begin
      last_now = 1'b0;
    end
  end

  assign fire = busy_r && (!emit_ok || slot_free);

  always_comb begin
    pending_nxt   = pending_r;
    busy_nxt      = busy_r;
    tail_nxt      = tail_r;
    pc_nxt        = pc_r;
    main_nxt      = main_r;
    cp_nxt        = cp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (accept) begin
      cp_nxt      = in_code_point;
      pending_nxt = (in_command == CMD_ENCODE) && (in_code_point == CH_CR);
      main_nxt    = route.entry;
      tail_nxt    = 1'b0;
      if (in_command == CMD_FINISH) begin
        busy_nxt = pending_r;
        pc_nxt   = A_CRPFX;
      end else if (in_code_point == CH_LF) begin
        busy_nxt = 1'b1;
        pc_nxt   = pending_r ? A_LF_CR : A_LF;
      end else if (pending_r) begin
        busy_nxt = 1'b1;
        pc_nxt   = A_CRPFX;
        tail_nxt = route.has;
      end else begin
        busy_nxt = route.has;
        pc_nxt   = route.entry;
      end
    end else if (fire) begin
      if (emit_ok) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ch;
        out_last_nxt  = last_now;
      end
      unique case (cw.op)
        OP_NEXT: pc_nxt = pc_r + PC_W'(1);
        OP_TAIL: begin
          if (tail_r) begin
            pc_nxt   = main_r;
            tail_nxt = 1'b0;
          end else begin
            busy_nxt = 1'b0;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r      <= 1'b0;
      busy_r         <= 1'b0;
      tail_r         <= 1'b0;
      pc_r           <= '0;
      out_valid_r    <= 1'b0;
      quote_double_r <= 1'b1;
      escape_high_r  <= 1'b1;
      eol_length_r   <= 2'd0;
      eol_first_r    <= '0;
      eol_second_r   <= '0;
    end else begin
      pending_r   <= pending_nxt;
      busy_r      <= busy_nxt;
      tail_r      <= tail_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_QUOTE_DOUBLE: quote_double_r <= cfg_data[0];
          REG_ESCAPE_HIGH:  escape_high_r  <= cfg_data[0];
          REG_EOL_LENGTH:   eol_length_r   <= cfg_data[1:0];
          REG_EOL_FIRST:    eol_first_r    <= cfg_data;
          REG_EOL_SECOND:   eol_second_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    main_r     <= main_nxt;
    cp_r       <= cp_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // A word left waiting after its routine ended must close its item.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !busy_r) |-> out_last_r)
    else $error("word waiting after routine end lacks last mark");

  // A chained routine is only recorded while the sequencer runs.
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> busy_r)
    else $error("chained routine recorded while idle");

  // A CR is held after it is accepted.
  a_cr_held: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_ENCODE && in_code_point == CH_CR) |=> pending_r)
    else $error("carriage return not held");

  // A finish with nothing held produces no work.
  a_empty_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_FINISH && !pending_r) |=> !busy_r)
    else $error("empty finish started a routine");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the string escape encoder: stimulus, prediction and checking.
module testbench;
  import see_pkg::*;

  localparam int unsigned EOL_LIMIT = 2;
  localparam int unsigned EOL_REGS  = 2;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_PER_PHASE = 50;
  localparam int unsigned MAX_REPORTS = 40;

  // Letters that follow the backslash in the escaped output, hex digit bases and code point bounds.
  localparam logic [CP_W-1:0] CH_LOWER_R = 21'h72;
  localparam logic [CP_W-1:0] CH_LOWER_N = 21'h6E;
  localparam logic [CP_W-1:0] CH_LOWER_T = 21'h74;
  localparam logic [CP_W-1:0] CH_LOWER_B = 21'h62;
  localparam logic [CP_W-1:0] CH_LOWER_F = 21'h66;
  localparam logic [CP_W-1:0] CH_LOWER_X = 21'h78;
  localparam logic [CP_W-1:0] CH_LOWER_U = 21'h75;
  localparam logic [CP_W-1:0] CH_UPPER_U = 21'h55;
  localparam logic [CP_W-1:0] CH_DIGIT_0 = 21'h30;
  localparam logic [CP_W-1:0] CH_UPPER_A = 21'h41;
  localparam logic [CP_W-1:0] CP_ALL_ONES = 21'h1FFFFF;
  localparam logic [CP_W-1:0] CP_UNICODE_TOP = 21'h10FFFF;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_EOL_SECOND + 3'd1;

  typedef struct {
    logic [CP_W-1:0] ch;
    logic            last;
  } esc_word_t;

  class escape_tracker;
    bit              quote_double;
    bit              escape_high;
    logic [1:0]      eol_len;
    logic [CP_W-1:0] eol_first;
    logic [CP_W-1:0] eol_second;
    bit              cr_held;
    int              failures;
    logic [CP_W-1:0] step_chars[$];
    esc_word_t       owed_words[$];

    function void reset_state();
      quote_double = 1'b1;
      escape_high  = 1'b1;
      eol_len      = 2'd0;
      eol_first    = '0;
      eol_second   = '0;
      cr_held      = 1'b0;
      failures     = 0;
      step_chars.delete();
      owed_words.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CP_W-1:0] data);
      case (idx)
        REG_QUOTE_DOUBLE: quote_double = data[0];
        REG_ESCAPE_HIGH:  escape_high  = data[0];
        REG_EOL_LENGTH:   eol_len      = data[1:0];
        REG_EOL_FIRST:    eol_first    = data;
        REG_EOL_SECOND:   eol_second   = data;
        default: ;
      endcase
    endfunction

    function void add_eol();
      int unsigned n;
      n = {30'd0, eol_len};
      if (n > EOL_LIMIT) n = EOL_LIMIT;
      if (n > EOL_REGS) n = EOL_REGS;
      if (n >= 1) step_chars.push_back(eol_first);
      if (n >= 2) step_chars.push_back(eol_second);
    endfunction

    function void add_hex(logic [CP_W-1:0] cp, int digits);
      logic [31:0] wide;
      logic [3:0]  nib;
      wide = {11'd0, cp};
      for (int i = digits - 1; i >= 0; i--) begin
        nib = wide[i*4 +: 4];
        if (nib < 4'd10) step_chars.push_back(CH_DIGIT_0 + CP_W'(nib));
        else step_chars.push_back(CH_UPPER_A + CP_W'(nib) - CP_W'(10));
      end
    endfunction

    function void add_cr_break();
      step_chars.push_back(CH_BSLASH);
      step_chars.push_back(CH_LOWER_R);
      add_eol();
    endfunction

    // Works out every output word one accepted item causes.
    function void note_item(logic cmd, logic [CP_W-1:0] cp);
      bit was_cr;
      esc_word_t w;
      was_cr = cr_held;
      cr_held = 1'b0;
      step_chars.delete();
      if (cmd == CMD_FINISH) begin
        if (was_cr) add_cr_break();
      end else if (cp == CH_LF) begin
        if (was_cr) begin
          step_chars.push_back(CH_BSLASH);
          step_chars.push_back(CH_LOWER_R);
        end
        step_chars.push_back(CH_BSLASH);
        step_chars.push_back(CH_LOWER_N);
        add_eol();
      end else begin
        if (was_cr) add_cr_break();
        if (cp < CH_SPACE || cp == CH_DEL) begin
          if (cp == CH_TAB) begin
            step_chars.push_back(CH_BSLASH);
            step_chars.push_back(CH_LOWER_T);
          end else if (cp == CH_CR) begin
            cr_held = 1'b1;
          end else if (cp == CH_BS) begin
            step_chars.push_back(CH_BSLASH);
            step_chars.push_back(CH_LOWER_B);
          end else if (cp == CH_FF) begin
            step_chars.push_back(CH_BSLASH);
            step_chars.push_back(CH_LOWER_F);
          end else begin
            step_chars.push_back(CH_BSLASH);
            step_chars.push_back(CH_LOWER_X);
            add_hex(cp, 2);
          end
        end else if (cp < CH_HIGH || !escape_high) begin
          if ((quote_double && cp == CH_DQUOTE) || (!quote_double && cp == CH_SQUOTE) ||
              cp == CH_BSLASH) begin
            step_chars.push_back(CH_BSLASH);
          end
          step_chars.push_back(cp);
        end else if (cp < CH_ASTRAL) begin
          step_chars.push_back(CH_BSLASH);
          step_chars.push_back(CH_LOWER_U);
          add_hex(cp, 4);
        end else begin
          step_chars.push_back(CH_BSLASH);
          step_chars.push_back(CH_UPPER_U);
          add_hex(cp, 8);
        end
      end
      foreach (step_chars[i]) begin
        w.ch = step_chars[i];
        w.last = (i == step_chars.size() - 1);
        owed_words.push_back(w);
      end
    endfunction

    function void check_word(logic [CP_W-1:0] ch, logic last);
      esc_word_t w;
      if (owed_words.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("%0t: unexpected output word, expected none, got char %h last %b",
                   $time, ch, last);
        failures++;
        return;
      end
      w = owed_words.pop_front();
      if (ch !== w.ch) begin
        if (failures < MAX_REPORTS)
          $display("%0t: out_char mismatch, expected %h, got %h", $time, w.ch, ch);
        failures++;
      end
      if (last !== w.last) begin
        if (failures < MAX_REPORTS)
          $display("%0t: out_last mismatch, expected %b, got %b", $time, w.last, last);
        failures++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [CP_W-1:0]      in_code_point;
  logic                 out_valid;
  logic                 out_ready;
  logic [CP_W-1:0]      out_char;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CP_W-1:0]      cfg_data;

  bit idle_on;
  escape_tracker tracker;

  string_escape_encoder #(
    .EOL_MAX_LEN(EOL_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_code_point(in_code_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("string_escape_encoder verification failed");
    $finish;
  end

  // Receiver side: random stall bursts while idling is on.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_word(out_char, out_last);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic cmd, input logic [CP_W-1:0] cp);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_code_point <= cp;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(cmd, cp);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CP_W-1:0] qd, input logic [CP_W-1:0] eh,
                              input logic [CP_W-1:0] len, input logic [CP_W-1:0] first,
                              input logic [CP_W-1:0] second);
    logic [CFG_IDX_W-1:0] spare;
    spare = REG_SPARE + CFG_IDX_W'($urandom_range(0, 2));
    write_reg(REG_QUOTE_DOUBLE, qd);
    write_reg(REG_ESCAPE_HIGH, eh);
    write_reg(REG_EOL_LENGTH, len);
    write_reg(REG_EOL_FIRST, first);
    write_reg(REG_EOL_SECOND, second);
    write_reg(spare, CP_W'($urandom_range(0, CP_ALL_ONES)));
    cfg_valid <= 1'b0;
  endtask

  // Lets every owed word come out, then gives a held-CR item time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.owed_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned pick;
    logic [CP_W-1:0] cp;
    logic cmd;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      cmd = CMD_ENCODE;
      if (pick < 30) begin
        cp = CP_W'($urandom_range(32, 126));
      end else if (pick < 38) begin
        case ($urandom_range(0, 2))
          0: cp = CH_DQUOTE;
          1: cp = CH_SQUOTE;
          default: cp = CH_BSLASH;
        endcase
      end else if (pick < 50) begin
        cp = CH_CR;
      end else if (pick < 58) begin
        cp = CH_LF;
      end else if (pick < 66) begin
        cp = CP_W'($urandom_range(0, 32));
        if (cp == CH_SPACE) cp = CH_DEL;
      end else if (pick < 78) begin
        cp = CP_W'($urandom_range(CH_HIGH, CH_ASTRAL - 1));
      end else if (pick < 86) begin
        cp = CP_W'($urandom_range(CH_ASTRAL, CP_UNICODE_TOP));
      end else if (pick < 92) begin
        cp = CP_W'($urandom_range(CP_UNICODE_TOP + 1, CP_ALL_ONES));
      end else begin
        cmd = CMD_FINISH;
        cp = CP_W'($urandom_range(0, CP_ALL_ONES));
      end
      send_item(cmd, cp);
    end
  endtask

  initial begin
    tracker = new();
    tracker.reset_state();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_ENCODE;
    in_code_point = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_QUOTE_DOUBLE;
    cfg_data      = '0;
    idle_on       = 1'b1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass on the reset settings.
    send_item(CMD_ENCODE, CH_UPPER_A);
    send_item(CMD_ENCODE, CH_DQUOTE);
    send_item(CMD_ENCODE, CH_SQUOTE);
    send_item(CMD_ENCODE, CH_BSLASH);
    send_item(CMD_ENCODE, CH_TAB);
    send_item(CMD_ENCODE, CH_BS);
    send_item(CMD_ENCODE, CH_FF);
    send_item(CMD_ENCODE, '0);
    send_item(CMD_ENCODE, CH_SPACE - 21'd1);
    send_item(CMD_ENCODE, CH_DEL);
    send_item(CMD_ENCODE, CH_LF);
    send_item(CMD_ENCODE, CH_CR);
    send_item(CMD_ENCODE, CH_LF);
    send_item(CMD_ENCODE, CH_CR);
    send_item(CMD_ENCODE, CH_CR);
    send_item(CMD_ENCODE, CH_LOWER_X);
    send_item(CMD_FINISH, CP_ALL_ONES);
    send_item(CMD_ENCODE, CH_HIGH);
    send_item(CMD_ENCODE, CH_ASTRAL - 21'd1);
    send_item(CMD_ENCODE, CH_ASTRAL);
    send_item(CMD_ENCODE, CP_ALL_ONES);
    send_item(CMD_ENCODE, CH_CR);
    send_item(CMD_FINISH, '0);
    drain();

    // Single quotes, no high escapes, an over-long line end of extreme characters.
    program_regs('0, '0, 21'd3, CP_ALL_ONES, '0);
    send_item(CMD_ENCODE, CH_CR);
    run_random(RANDOM_PER_PHASE);
    drain();

    idle_on = 1'b0;
    program_regs(21'd1, 21'd1, 21'd1, CP_W'($urandom_range(0, CP_ALL_ONES)),
                 CP_W'($urandom_range(0, CP_ALL_ONES)));
    run_random(RANDOM_PER_PHASE);
    drain();

    idle_on = 1'b1;
    program_regs(CP_W'($urandom_range(0, CP_ALL_ONES)), CP_W'($urandom_range(0, CP_ALL_ONES)),
                 21'd2, CH_CR, CH_LF);
    run_random(RANDOM_PER_PHASE);
    drain();

    // Full-width random data into every register; only the low bits of the flag and length registers should count.
    idle_on = 1'b0;
    program_regs(CP_W'($urandom_range(0, CP_ALL_ONES)), CP_W'($urandom_range(0, CP_ALL_ONES)),
                 CP_W'($urandom_range(0, CP_ALL_ONES)), CP_W'($urandom_range(0, CP_ALL_ONES)),
                 CP_W'($urandom_range(0, CP_ALL_ONES)));
    run_random(RANDOM_PER_PHASE);
    send_item(CMD_FINISH, '0);
    drain();

    if (tracker.failures == 0) begin
      $display("string_escape_encoder verification clean");
    end else begin
      $display("string_escape_encoder verification failed");
    end
    $finish;
  end

endmodule
